// ===== rtl/sdrs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdrs_pkg
// shared types and constants of the scan disk request scheduler
// ----------------------------------------------------------------------------
package sdrs_pkg;

  localparam int CYL_W      = 8;
  localparam int CLK_W      = 31;
  localparam int SUM_W      = 32;
  localparam int ORD_W      = 32;
  localparam int LIMIT_W    = 10;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 10;

  localparam int DEF_TABLE_DEPTH   = 512;
  localparam int DEF_LAST_CYLINDER = 255;

  localparam logic [LIMIT_W-1:0] DEF_QUEUE_LIMIT = 10'd128;
  localparam logic [CYL_W-1:0]   DEF_START_HEAD  = 8'd53;

  localparam logic [CLK_W-1:0] CLOCK_MAX = {CLK_W{1'b1}};
  localparam logic [SUM_W-1:0] SUM_MAX   = {SUM_W{1'b1}};

  typedef enum logic {
    CMD_SUBMIT = 1'b0,
    CMD_DRAIN  = 1'b1
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_QUEUE_LIMIT = 1'b0,
    REG_START_HEAD  = 1'b1
  } reg_idx_t;

  // one pending request as held in the table memory
  typedef struct packed {
    logic [CYL_W-1:0] cyl;
    logic [CLK_W-1:0] arrival;
    logic [ORD_W-1:0] order;
  } slot_t;

  // request chosen for service and the arm direction afterwards
  typedef struct packed {
    logic [CYL_W-1:0] cyl;
    logic [CLK_W-1:0] arrival;
    logic             moving_right;
  } pick_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_CLOCK,
    S_WAIT,
    S_STATS,
    S_MOVE_WR,
    S_INSERT,
    S_DONE
  } state_t;

endpackage

// ===== rtl/scan_disk_request_scheduler_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scan_disk_request_scheduler_core
// elevator (scan) disk arm scheduler over a table of pending requests
// ----------------------------------------------------------------------------
// Each input item is a submit or a drain and gives exactly one result item.
// Pending requests sit densely packed in one table memory (entries 0 to
// pending-1, cylinder, arrival stamp and insertion order). A service reads
// the whole table once, one entry a cycle through the registered read port,
// then picks the request, updates the arm clock and statistics in a few
// steps, and closes the gap by copying the last entry into the served slot.
// A submit that serves then also inserts its own request; an item without
// service skips the scan and goes straight to the insert (submit) or to the
// result (drain). The time an item takes grows with the table scan, and a
// result still waiting adds its wait.
// One item is worked on at a time; the result sits in an output register so
// the next item is taken while it waits.
// There is no clearing pass after reset: the fill count marks what is valid.
// Writing start_head also moves the arm at once.
// ----------------------------------------------------------------------------
module scan_disk_request_scheduler_core
  import sdrs_pkg::*;
#(
  parameter int TABLE_DEPTH   = DEF_TABLE_DEPTH,
  parameter int LAST_CYLINDER = DEF_LAST_CYLINDER,
  localparam int IDX_W        = $clog2(TABLE_DEPTH),
  localparam int CNT_W        = $clog2(TABLE_DEPTH + 1)
) (
  input  logic                    clk,
  input  logic                    rst_n,
  // configuration
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_wdata,
  // input items
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    in_command,
  input  logic [CYL_W-1:0]        in_cylinder,
  // result items
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic                    out_served,
  output logic [CYL_W-1:0]        out_served_cylinder,
  output logic [CLK_W-1:0]        out_wait_time,
  output logic [SUM_W-1:0]        out_total_distance,
  output logic [SUM_W-1:0]        out_total_wait,
  output logic [CLK_W-1:0]        out_min_wait,
  output logic signed [SUM_W-1:0] out_max_wait,
  output logic [SUM_W-1:0]        out_request_count,
  output logic [CNT_W-1:0]        out_pending
);

  localparam int COST_W = $clog2(2 * LAST_CYLINDER + 256 + 1);
  localparam int LIM_W  = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;
  localparam int CS_W   = CLK_W + 1;
  localparam int SS_W   = SUM_W + 1;

  // request table
  slot_t mem [TABLE_DEPTH];
  slot_t rd_data_r;

  state_t state_r, state_nxt;

  logic [LIMIT_W-1:0]      queue_limit_r;
  logic [CNT_W-1:0]        cnt_r;
  logic [ORD_W-1:0]        seq_r;
  logic [CYL_W-1:0]        head_r;
  logic                    moving_right_r;
  logic [CLK_W-1:0]        arm_clock_r;
  logic [SUM_W-1:0]        dist_sum_r;
  logic [SUM_W-1:0]        wait_sum_r;
  logic [CLK_W-1:0]        wait_min_r;
  logic signed [SUM_W-1:0] wait_max_r;
  logic [SUM_W-1:0]        submit_cnt_r;

  // item in flight
  logic                    cmd_r;
  logic [CYL_W-1:0]        cyl_r;
  logic                    srv_r;
  logic [CNT_W-1:0]        scan_idx_r;
  logic                    rd_vld_r;
  logic [IDX_W-1:0]        rd_idx_r;
  pick_t                   pick_r;
  logic [IDX_W-1:0]        pick_idx_r;
  logic [COST_W-1:0]       cost_r;
  logic [CLK_W-1:0]        wait_r;

  logic                    out_valid_r;

  // memory controls
  logic                    mem_re, mem_we;
  logic [IDX_W-1:0]        mem_raddr, mem_waddr;
  slot_t                   mem_wdata;
  logic                    sel_clear;
  logic                    out_load;

  logic                    in_fire;
  logic [LIM_W-1:0]        limit_eff;
  logic                    serve_now;

  pick_t                   sel_pick;
  logic [IDX_W-1:0]        sel_idx;
  logic [COST_W-1:0]       sel_cost;

  assign in_fire   = in_valid && in_ready;
  // a limit above the table size acts as the table size
  assign limit_eff = (LIM_W'(queue_limit_r) > LIM_W'(TABLE_DEPTH)) ?
                     LIM_W'(TABLE_DEPTH) : LIM_W'(queue_limit_r);
  // a full table (or a drain) serves first; an empty one never serves
  assign serve_now = (cnt_r != '0) &&
                     ((in_command == CMD_DRAIN) || (LIM_W'(cnt_r) >= limit_eff));

  sdrs_select #(
    .LAST_CYLINDER (LAST_CYLINDER),
    .IDX_W         (IDX_W)
  ) u_select (
    .clk          (clk),
    .rst_n        (rst_n),
    .clear        (sel_clear),
    .ent_vld      (rd_vld_r),
    .ent          (rd_data_r),
    .ent_idx      (rd_idx_r),
    .head         (head_r),
    .seq          (seq_r),
    .moving_right (moving_right_r),
    .pick         (sel_pick),
    .pick_idx     (sel_idx),
    .pick_cost    (sel_cost)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (serve_now)                    state_nxt = S_SCAN;
          else if (in_command == CMD_SUBMIT) state_nxt = S_INSERT;
          else                              state_nxt = S_DONE;
        end
      end
      S_SCAN: begin
        if ((scan_idx_r == cnt_r) && !rd_vld_r) state_nxt = S_DECIDE;
      end
      S_DECIDE:  state_nxt = S_CLOCK;
      S_CLOCK:   state_nxt = S_WAIT;
      S_WAIT:    state_nxt = S_STATS;
      S_STATS:   state_nxt = S_MOVE_WR;
      S_MOVE_WR: state_nxt = (cmd_r == CMD_SUBMIT) ? S_INSERT : S_DONE;
      S_INSERT:  state_nxt = S_DONE;
      S_DONE: begin
        if (!out_valid_r || out_ready) state_nxt = S_IDLE;
      end
      default:   state_nxt = S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_ready  = 1'b0;
    mem_re    = 1'b0;
    mem_raddr = scan_idx_r[IDX_W-1:0];
    mem_we    = 1'b0;
    mem_waddr = pick_idx_r;
    mem_wdata = rd_data_r;
    sel_clear = 1'b0;
    out_load  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready  = 1'b1;
        sel_clear = 1'b1;
      end
      S_SCAN: begin
        mem_re = (scan_idx_r != cnt_r);
      end
      S_STATS: begin
        // fetch the last entry to fill the served slot
        mem_re    = 1'b1;
        mem_raddr = IDX_W'(cnt_r - 1'b1);
      end
      S_MOVE_WR: begin
        mem_we = 1'b1;
      end
      S_INSERT: begin
        mem_we            = 1'b1;
        mem_waddr         = cnt_r[IDX_W-1:0];
        mem_wdata.cyl     = cyl_r;
        mem_wdata.arrival = arm_clock_r;
        mem_wdata.order   = seq_r;
      end
      S_DONE: begin
        out_load = !out_valid_r || out_ready;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  // table memory, one write and one registered read a cycle
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) rd_data_r <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  // saturating sums
  logic [CS_W-1:0] clk_sum;
  logic [SS_W-1:0] dist_sum, wait_sum, submit_sum;

  assign clk_sum    = CS_W'(arm_clock_r) + CS_W'(cost_r);
  assign dist_sum   = SS_W'(dist_sum_r) + SS_W'(cost_r);
  assign wait_sum   = SS_W'(wait_sum_r) + SS_W'(wait_r);
  assign submit_sum = SS_W'(submit_cnt_r) + SS_W'(1'b1);

  // scheduler state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      queue_limit_r  <= DEF_QUEUE_LIMIT;
      head_r         <= DEF_START_HEAD;
      cnt_r          <= '0;
      seq_r          <= '0;
      moving_right_r <= 1'b1;
      arm_clock_r    <= '0;
      dist_sum_r     <= '0;
      wait_sum_r     <= '0;
      wait_min_r     <= CLOCK_MAX;
      wait_max_r     <= '1;
      submit_cnt_r   <= '0;
      rd_vld_r       <= 1'b0;
    end else begin
      rd_vld_r <= (state_r == S_SCAN) && mem_re;
      if (cfg_we) begin
        case (cfg_index)
          REG_QUEUE_LIMIT: queue_limit_r <= cfg_wdata[LIMIT_W-1:0];
          REG_START_HEAD:  head_r        <= cfg_wdata[CYL_W-1:0];
          default:         queue_limit_r <= queue_limit_r;
        endcase
      end
      case (state_r)
        S_DECIDE: begin
          head_r         <= sel_pick.cyl;
          moving_right_r <= sel_pick.moving_right;
        end
        S_CLOCK: begin
          arm_clock_r <= clk_sum[CLK_W] ? CLOCK_MAX : clk_sum[CLK_W-1:0];
          dist_sum_r  <= dist_sum[SUM_W] ? SUM_MAX : dist_sum[SUM_W-1:0];
        end
        S_STATS: begin
          wait_sum_r <= wait_sum[SUM_W] ? SUM_MAX : wait_sum[SUM_W-1:0];
          if (wait_r < wait_min_r) wait_min_r <= wait_r;
          if ($signed({1'b0, wait_r}) > wait_max_r) wait_max_r <= $signed({1'b0, wait_r});
        end
        S_MOVE_WR: begin
          cnt_r <= cnt_r - 1'b1;
        end
        S_INSERT: begin
          cnt_r        <= cnt_r + 1'b1;
          seq_r        <= seq_r + 1'b1;
          submit_cnt_r <= submit_sum[SUM_W] ? SUM_MAX : submit_sum[SUM_W-1:0];
        end
        default: begin
          cnt_r <= cnt_r;
        end
      endcase
    end
  end

  // item payload and per-service working registers
  always_ff @(posedge clk) begin
    rd_idx_r <= mem_raddr;
    if (in_fire) begin
      cmd_r      <= in_command;
      cyl_r      <= in_cylinder;
      srv_r      <= serve_now;
      scan_idx_r <= '0;
    end
    if ((state_r == S_SCAN) && mem_re) scan_idx_r <= scan_idx_r + 1'b1;
    if (state_r == S_DECIDE) begin
      pick_r     <= sel_pick;
      pick_idx_r <= sel_idx;
      cost_r     <= sel_cost;
    end
    if (state_r == S_WAIT) begin
      // clock saturates, so an arrival stamp can never be ahead of it
      wait_r <= (arm_clock_r >= pick_r.arrival) ? (arm_clock_r - pick_r.arrival) : '0;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_served          <= srv_r;
      out_served_cylinder <= head_r;
      out_wait_time       <= srv_r ? wait_r : '0;
      out_total_distance  <= dist_sum_r;
      out_total_wait      <= wait_sum_r;
      out_min_wait        <= wait_min_r;
      out_max_wait        <= wait_max_r;
      out_request_count   <= submit_cnt_r;
      out_pending         <= cnt_r;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ===== rtl/sdrs_select.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdrs_select
// keeps the best candidate at, below and above the head during a table scan
// and picks the request to serve with its arm movement cost
// ----------------------------------------------------------------------------
module sdrs_select
  import sdrs_pkg::*;
#(
  parameter int LAST_CYLINDER = DEF_LAST_CYLINDER,
  parameter int IDX_W         = 9,
  localparam int COST_W       = $clog2(2 * LAST_CYLINDER + 256 + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              clear,
  input  logic              ent_vld,
  input  slot_t             ent,
  input  logic [IDX_W-1:0]  ent_idx,
  input  logic [CYL_W-1:0]  head,
  input  logic [ORD_W-1:0]  seq,
  input  logic              moving_right,
  output pick_t             pick,
  output logic [IDX_W-1:0]  pick_idx,
  output logic [COST_W-1:0] pick_cost
);

  logic             here_vld_r, below_vld_r, above_vld_r;
  logic [ORD_W-1:0] here_age_r, below_age_r, above_age_r;
  logic [CLK_W-1:0] here_arr_r, below_arr_r, above_arr_r;
  logic [IDX_W-1:0] here_idx_r, below_idx_r, above_idx_r;
  logic [CYL_W-1:0] below_cyl_r, above_cyl_r;

  logic [ORD_W-1:0] ent_age;
  logic             here_upd, below_upd, above_upd;

  assign ent_age = seq - ent.order;

  // at head: oldest; below: nearest then newest; above: nearest then oldest
  assign here_upd  = ent_vld && (ent.cyl == head) &&
                     (!here_vld_r || (ent_age > here_age_r));
  assign below_upd = ent_vld && (ent.cyl < head) &&
                     (!below_vld_r || (ent.cyl > below_cyl_r) ||
                      ((ent.cyl == below_cyl_r) && (ent_age < below_age_r)));
  assign above_upd = ent_vld && (ent.cyl > head) &&
                     (!above_vld_r || (ent.cyl < above_cyl_r) ||
                      ((ent.cyl == above_cyl_r) && (ent_age > above_age_r)));

  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      here_vld_r  <= 1'b0;
      below_vld_r <= 1'b0;
      above_vld_r <= 1'b0;
    end else begin
      if (here_upd)  here_vld_r  <= 1'b1;
      if (below_upd) below_vld_r <= 1'b1;
      if (above_upd) above_vld_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (here_upd) begin
      here_age_r <= ent_age;
      here_arr_r <= ent.arrival;
      here_idx_r <= ent_idx;
    end
    if (below_upd) begin
      below_age_r <= ent_age;
      below_arr_r <= ent.arrival;
      below_idx_r <= ent_idx;
      below_cyl_r <= ent.cyl;
    end
    if (above_upd) begin
      above_age_r <= ent_age;
      above_arr_r <= ent.arrival;
      above_idx_r <= ent_idx;
      above_cyl_r <= ent.cyl;
    end
  end

  logic [COST_W-1:0] edge_cost;
  logic [CYL_W-1:0]  move_dist;
  logic              take_here, take_above;

  always_comb begin
    edge_cost         = '0;
    pick.moving_right = moving_right;
    take_here         = 1'b0;
    take_above        = 1'b0;
    if (here_vld_r) begin
      take_here = 1'b1;
    end else if (!below_vld_r) begin
      // nothing on the left: bounce off cylinder 0 if sweeping left
      if (!moving_right) begin
        edge_cost = COST_W'(head) + COST_W'(head);
      end
      pick.moving_right = 1'b1;
      take_above        = 1'b1;
    end else if (!above_vld_r) begin
      // nothing on the right: bounce off the last cylinder
      if (moving_right) begin
        if (COST_W'(head) < COST_W'(LAST_CYLINDER)) begin
          edge_cost = (COST_W'(LAST_CYLINDER) - COST_W'(head)) << 1;
        end
      end
      pick.moving_right = 1'b0;
    end else begin
      take_above = moving_right;
    end

    if (take_here) begin
      pick.cyl     = head;
      pick.arrival = here_arr_r;
      pick_idx     = here_idx_r;
    end else if (take_above) begin
      pick.cyl     = above_cyl_r;
      pick.arrival = above_arr_r;
      pick_idx     = above_idx_r;
    end else begin
      pick.cyl     = below_cyl_r;
      pick.arrival = below_arr_r;
      pick_idx     = below_idx_r;
    end

    move_dist = (pick.cyl >= head) ? (pick.cyl - head) : (head - pick.cyl);
    pick_cost = edge_cost + COST_W'(move_dist);
  end

endmodule
